// File: hdl/b58dec_pkg.sv
package b58dec_pkg;

    localparam int ACC_BYTES     = 128;
    localparam int MAX_OUT_BYTES = 64;
    localparam int ACC_AW        = $clog2(ACC_BYTES);
    localparam int CNT_W         = ACC_AW + 1;
    localparam int POS_W         = (MAX_OUT_BYTES > 1) ? $clog2(MAX_OUT_BYTES) : 1;
    localparam int DIGIT_W       = 6;
    localparam int LEN_W         = 7;
    localparam int LEAD_W        = 7;

    localparam logic [LEAD_W-1:0] LEAD_SAT  = LEAD_W'(65);
    localparam logic [7:0]        CHAR_ONE  = 8'h31;
    localparam logic [5:0]        RADIX     = 6'd58;
    localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(32);

    typedef struct packed {
        logic               start;
        logic [DIGIT_W-1:0] digit;
        logic [CNT_W-1:0]   span;
        logic [CNT_W-1:0]   used;
        logic               app_we;
        logic [ACC_AW-1:0]  rd_addr;
    } acc_cmd_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] carry;
        logic [7:0]         rd_data;
    } acc_stat_t;

    // Bitcoin alphabet lookup; bit 6 of the result flags a valid character.
    function automatic logic [DIGIT_W:0] digit_of(input logic [7:0] ch);
        logic [DIGIT_W:0] r;
        r = '0;
        if (ch >= 8'h31 && ch <= 8'h39) r = {1'b1, 6'(ch - 8'h31)};
        else if (ch >= 8'h41 && ch <= 8'h48) r = {1'b1, 6'(ch - 8'h41 + 8'd9)};
        else if (ch >= 8'h4a && ch <= 8'h4e) r = {1'b1, 6'(ch - 8'h4a + 8'd17)};
        else if (ch >= 8'h50 && ch <= 8'h5a) r = {1'b1, 6'(ch - 8'h50 + 8'd22)};
        else if (ch >= 8'h61 && ch <= 8'h6b) r = {1'b1, 6'(ch - 8'h61 + 8'd33)};
        else if (ch >= 8'h6d && ch <= 8'h7a) r = {1'b1, 6'(ch - 8'h6d + 8'd44)};
        return r;
    endfunction

endpackage

// File: hdl/b58dec_accum.sv
module b58dec_accum
    import b58dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  acc_cmd_t  cmd,
    output acc_stat_t stat
);

    logic [7:0]         mem [ACC_BYTES];
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [DIGIT_W-1:0] carry_reg, carry_next;
    logic [7:0]         rdata_reg;
    logic [ACC_AW-1:0]  rd_addr;
    logic [CNT_W-1:0]   j_inc;
    logic [7:0]         cur_byte;
    logic [13:0]        sum;
    logic               we;
    logic [ACC_AW-1:0]  wr_addr;
    logic [7:0]         wr_data;

    assign j_inc    = j_reg + CNT_W'(1);
    // Entries at or above the fill count were never written in this string.
    assign cur_byte = (j_reg < cmd.used) ? rdata_reg : 8'h00;
    assign sum      = 14'(carry_reg) + 14'(cur_byte) * 14'(RADIX);
    assign rd_addr  = run_reg ? j_inc[ACC_AW-1:0] : cmd.rd_addr;

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        j_next     = j_reg;
        carry_next = carry_reg;
        we         = 1'b0;
        wr_addr    = cmd.used[ACC_AW-1:0];
        wr_data    = 8'(carry_reg);
        if (run_reg)
        begin
            we         = 1'b1;
            wr_addr    = j_reg[ACC_AW-1:0];
            wr_data    = sum[7:0];
            carry_next = sum[13:8];
            j_next     = j_inc;
            if (j_inc == cmd.span)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (cmd.start)
        begin
            run_next   = 1'b1;
            j_next     = '0;
            carry_next = cmd.digit;
        end
        else if (cmd.app_we)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        carry_reg <= carry_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign stat.done    = done_reg;
    assign stat.carry   = carry_reg;
    assign stat.rd_data = rdata_reg;

endmodule

// File: hdl/base58_text_to_bytes_decoder.sv
// Base58 decoder, Bitcoin alphabet. Text enters one character per input beat
// with end_of_text on the last one; leading '1' characters are counted and
// the rest are folded into a 128-byte accumulator by a shared multiply-by-58
// unit that walks one accumulator byte per cycle. A digit character runs a
// multiply pass and an append step; no new character is taken meanwhile.
// After the last character the block sends output_length bytes, most
// significant first, each via the read, load and send states and held
// until taken, or a single beat with failed set. The length register is
// to be written through the cfg channel only while the block is idle (not
// enforced by the block); it resets to 32.
module base58_text_to_bytes_decoder
    import b58dec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       text_char,
    input  logic             end_of_text,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             failed,
    output logic             final_byte
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAC    = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_FIN    = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_LOAD   = 3'd5;
    localparam logic [2:0] S_SEND   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [LEAD_W-1:0]  lead_reg, lead_next;
    logic               run1_reg, run1_next;
    logic               err_reg, err_next;
    logic               last_reg, last_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ovalid_reg, ovalid_next;
    logic [7:0]         obyte_reg, obyte_next;
    logic               ofail_reg, ofail_next;
    logic               ofinal_reg, ofinal_next;

    acc_cmd_t           cmd;
    acc_stat_t          stat;
    logic [CNT_W-1:0]   used_eff;
    logic [DIGIT_W:0]   dig;
    logic [CNT_W:0]     total;
    logic               bad_len;

    b58dec_accum u_accum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign used_eff  = (used_reg == '0) ? CNT_W'(1) : used_reg;
    assign dig       = digit_of(text_char);
    assign total     = (CNT_W+1)'(lead_reg) + (CNT_W+1)'(used_reg);
    assign bad_len   = (len_reg == '0) || (len_reg > LEN_W'(MAX_OUT_BYTES));
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        used_next   = used_reg;
        lead_next   = lead_reg;
        run1_next   = run1_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        ofail_next  = ofail_reg;
        ofinal_next = ofinal_reg;

        cmd.start   = 1'b0;
        cmd.digit   = dig[DIGIT_W-1:0];
        cmd.span    = used_eff;
        cmd.used    = used_reg;
        cmd.app_we  = 1'b0;
        cmd.rd_addr = '0;

        if (cfg_valid && cfg_ready)
        begin
            len_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = end_of_text;
                    state_next = end_of_text ? S_FIN : S_IDLE;
                    if (!err_reg)
                    begin
                        if (run1_reg && text_char == CHAR_ONE)
                        begin
                            if (lead_reg < LEAD_SAT)
                            begin
                                lead_next = lead_reg + LEAD_W'(1);
                            end
                        end
                        else
                        begin
                            run1_next = 1'b0;
                            if (!dig[DIGIT_W])
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = S_MAC;
                            end
                        end
                    end
                end
            end
            S_MAC:
            begin
                if (stat.done)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                // The carry out of the top byte is below 58, so at most one
                // new byte is needed.
                cmd.used  = used_eff;
                used_next = used_eff;
                if (stat.carry != '0)
                begin
                    if (used_eff == CNT_W'(ACC_BYTES))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        cmd.app_we = 1'b1;
                        used_next  = used_eff + CNT_W'(1);
                    end
                end
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                // The top byte in use is never zero, so the fill count is
                // already the trimmed length.
                if (err_reg || bad_len || total > (CNT_W+1)'(len_reg))
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = 8'h00;
                    ofail_next  = 1'b1;
                    ofinal_next = 1'b1;
                    state_next  = S_SEND;
                end
                else
                begin
                    pos_next   = POS_W'(len_reg - LEN_W'(1));
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_addr = ACC_AW'(pos_reg);
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                ovalid_next = 1'b1;
                obyte_next  = (CNT_W'(pos_reg) < used_reg) ? stat.rd_data : 8'h00;
                ofail_next  = 1'b0;
                ofinal_next = (pos_reg == '0);
                state_next  = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    ovalid_next = 1'b0;
                    if (ofinal_reg)
                    begin
                        used_next  = '0;
                        lead_next  = '0;
                        run1_next  = 1'b1;
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - POS_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= LEN_RESET;
            used_reg   <= '0;
            lead_reg   <= '0;
            run1_reg   <= 1'b1;
            err_reg    <= 1'b0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            used_reg   <= used_next;
            lead_reg   <= lead_next;
            run1_reg   <= run1_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        obyte_reg  <= obyte_next;
        ofail_reg  <= ofail_next;
        ofinal_reg <= ofinal_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_byte   = obyte_reg;
    assign failed     = ofail_reg;
    assign final_byte = ofinal_reg;

endmodule

// File: dv/base58_text_to_bytes_decoder_test.sv
`timescale 1ns / 1ps

module base58_text_to_bytes_decoder_test;
    import b58dec_pkg::*;

    localparam logic [8*58-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam int RADIX_N     = 58;
    localparam int RANDOM_CHARS = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       fail;
        logic       last;
    } byte_beat_t;

    class b58_scoreboard;
        logic [7:0]  acc [ACC_BYTES];
        int unsigned used;
        int unsigned lead;
        int unsigned len_cfg;
        bit          in_run;
        bit          bad;
        byte_beat_t  expected_q[$];
        int unsigned mismatches;

        function new();
            len_cfg    = LEN_RESET;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (acc[i]) acc[i] = 8'h00;
            used   = 1;
            lead   = 0;
            in_run = 1'b1;
            bad    = 1'b0;
        endfunction

        function void set_length(input logic [LEN_W-1:0] v);
            len_cfg = v;
        endfunction

        function int digit_value(input logic [7:0] ch);
            for (int k = 0; k < RADIX_N; k++)
            begin
                if (ALPHABET[8*(RADIX_N-1-k) +: 8] == ch)
                    return k;
            end
            return -1;
        endfunction

        function void mul_add(input int unsigned d);
            int unsigned carry;
            carry = d;
            for (int unsigned j = 0; j < used; j++)
            begin
                carry  = carry + acc[j] * RADIX_N;
                acc[j] = carry[7:0];
                carry  = carry >> 8;
            end
            while (carry > 0)
            begin
                if (used >= ACC_BYTES)
                begin
                    bad = 1'b1;
                    return;
                end
                acc[used] = carry[7:0];
                used++;
                carry = carry >> 8;
            end
        endfunction

        // Called once per accepted input beat; queues the bytes a string yields.
        function void note_char(input logic [7:0] ch, input logic eot);
            int          d;
            int unsigned n;
            byte_beat_t  beat;
            if (!bad)
            begin
                if (in_run && ch == CHAR_ONE)
                begin
                    if (lead < LEAD_SAT)
                        lead++;
                end
                else
                begin
                    in_run = 1'b0;
                    d = digit_value(ch);
                    if (d < 0)
                        bad = 1'b1;
                    else
                        mul_add(d);
                end
            end
            if (!eot)
                return;
            n = used;
            while (n > 0 && acc[n-1] == 8'h00)
                n--;
            if (bad || len_cfg == 0 || len_cfg > MAX_OUT_BYTES || lead + n > len_cfg)
            begin
                beat = '{data: 8'h00, fail: 1'b1, last: 1'b1};
                expected_q.push_back(beat);
            end
            else
            begin
                for (int unsigned j = 0; j < len_cfg; j++)
                begin
                    beat.data = (len_cfg - 1 - j < n) ? acc[len_cfg-1-j] : 8'h00;
                    beat.fail = 1'b0;
                    beat.last = (j + 1 == len_cfg);
                    expected_q.push_back(beat);
                end
            end
            clear_string();
        endfunction

        function void check(input logic [7:0] data, input logic fail, input logic last);
            byte_beat_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected output beat: out_byte %02h failed %0b final_byte %0b",
                       data, fail, last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte: expected %02h, got %02h", want.data, data);
                mismatches++;
            end
            if (fail !== want.fail)
            begin
                $error("failed: expected %0b, got %0b", want.fail, fail);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("final_byte: expected %0b, got %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       text_char = 8'h00;
    logic             end_of_text = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       out_byte;
    logic             failed;
    logic             final_byte;

    b58_scoreboard sb;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            stall_left = 0;

    base58_text_to_bytes_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .failed      (failed),
        .final_byte  (final_byte)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[base58_text_to_bytes_decoder] ERROR");
        $finish;
    end

    // Output side: check every accepted beat, then pick the next ready level.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check(out_byte, failed, final_byte);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 160);
            end
            stall_left--;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Input beats go out in bursts; a gap, when one is drawn, drops valid before a burst.
    task automatic send_char(input logic [7:0] ch, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid    <= 1'b1;
        text_char   <= ch;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_char(ch, eot);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_repeat(input logic [7:0] ch, input int count);
        for (int i = 0; i < count; i++)
            send_char(ch, i == count - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_length(v);
    endtask

    // Mostly well-formed strings sized around the output length, with some noise.
    task automatic send_random_string(input int len, output int sent);
        int         n_lead;
        int         n_dig;
        logic [7:0] ch;
        n_lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len + 1)
                                             : $urandom_range(0, 2);
        n_dig  = $urandom_range(0, len * 8 / 6 + 2);
        if (n_lead + n_dig == 0)
            n_dig = 1;
        sent = n_lead + n_dig;
        for (int i = 0; i < sent; i++)
        begin
            if (i < n_lead)
                ch = CHAR_ONE;
            else if ($urandom_range(0, 39) == 0)
                ch = 8'($urandom_range(0, 255));
            else
                ch = ALPHABET[8*(RADIX_N-1-$urandom_range(0, RADIX_N-1)) +: 8];
            send_char(ch, i == sent - 1);
        end
    endtask

    initial
    begin
        int total;
        int sent;
        int len;
        int strings;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length of 32.
        send_text("1");
        send_text("z");
        send_text("21");
        send_text("11JxG");
        send_char("2", 1'b0);
        send_char(8'h00, 1'b0);
        send_text("zz");
        send_char("3", 1'b0);
        send_char(8'hff, 1'b1);
        send_text("0");
        send_text("l");

        write_length(7'd64);
        send_text("123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz");
        send_repeat(CHAR_ONE, 64);
        send_repeat(CHAR_ONE, 70);
        // Enough top digits to carry past the last accumulator byte.
        send_repeat("z", 180);

        write_length(7'd1);
        send_text("1");
        send_text("2");
        send_text("5V");
        send_text("11");

        write_length(7'd0);
        send_text("2");
        write_length(7'd127);
        send_text("2");

        total   = 0;
        strings = 0;
        len     = 32;
        while (total < RANDOM_CHARS)
        begin
            if (strings % 4 == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       len = 64;
                    1:       len = 1;
                    2, 3:    len = $urandom_range(9, 40);
                    default: len = $urandom_range(1, 8);
                endcase
                write_length(LEN_W'(len));
            end
            send_random_string(len, sent);
            total += sent;
            strings++;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[base58_text_to_bytes_decoder] OK");
        else
            $display("[base58_text_to_bytes_decoder] ERROR");
        $finish;
    end
endmodule
